// ===== hdl/ssid_pkg.sv =====
// Shared types and constants for the sorted set insert/delete block.
package ssid_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [VALUE_W-1:0]  value;
    } request_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   count;
    } result_t;

    // Broadcast control for every cell of the chain.
    typedef struct packed {
        logic                       ins;
        logic                       del;
        logic signed [VALUE_W-1:0]  key;
    } cell_ctrl_t;

endpackage

// ===== hdl/ssid_cell.sv =====
// One compare-and-shift cell of the sorted table.
module ssid_cell
    import ssid_pkg::*;
(
    input  logic                       clk,
    input  cell_ctrl_t                 ctrl,
    input  logic                       occ,
    input  logic                       left_lt,
    input  logic signed [VALUE_W-1:0]  left_entry,
    input  logic signed [VALUE_W-1:0]  right_entry,
    output logic signed [VALUE_W-1:0]  entry,
    output logic                       lt,
    output logic                       eq
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    assign entry = entry_reg;
    assign lt    = occ && (entry_reg < ctrl.key);
    assign eq    = occ && (entry_reg == ctrl.key);

    // Cells below the sorted position hold; the first cell at or above it takes
    // the key on insert, the ones above take their lower neighbor. On delete
    // every cell from the match upward takes its upper neighbor.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && !lt)
        begin
            if (left_lt)
                entry_next = ctrl.key;
            else
                entry_next = left_entry;
        end
        else if (ctrl.del && !lt)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hdl/sorted_set_insert_delete.sv =====
// Top level of the sorted set insert/delete block: a chain of compare-and-shift cells.
//
// Usage: a request (opcode, value) is transferred at a rising edge where start
// is high and busy is low. Busy stays low, so a request may be given in every
// cycle: all cells compare the key against their entry and shift in the same
// cycle. The result (status, count) appears in the cycle after the transfer, on
// result with done high for exactly one cycle. The receiver cannot stall; the result
// register is rewritten by each new request.
// Status: ok, duplicate on insert, table full (checked before duplicate), or
// not found on delete. Count is the number of entries held after the request.
// Reset clears the entry count and the done strobe; the cells' contents are
// not cleared, since no cell at or above the count is ever compared.
module sorted_set_insert_delete
    import ssid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  request_t  request,
    output logic      done,
    output result_t   result
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    result_t          result_reg;
    result_t          result_next;

    logic                       accept;
    logic                       found;
    logic                       full;
    status_t                    status;
    cell_ctrl_t                 ctrl;
    logic [CAPACITY-1:0]        occ;
    logic [CAPACITY-1:0]        lt;
    logic [CAPACITY-1:0]        eq;
    logic signed [VALUE_W-1:0]  entries [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign found  = |eq;
    assign full   = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        unique case (request.opcode)
            OP_INSERT:
                status = full ? ST_FULL : (found ? ST_DUP : ST_OK);
            OP_DELETE:
                status = found ? ST_OK : ST_MISSING;
            default:
                status = ST_MISSING;
        endcase
    end

    assign ctrl.key = request.value;
    assign ctrl.ins = accept && (request.opcode == OP_INSERT) && (status == ST_OK);
    assign ctrl.del = accept && (request.opcode == OP_DELETE) && (status == ST_OK);

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                       left_lt;
            logic signed [VALUE_W-1:0]  left_entry;
            logic signed [VALUE_W-1:0]  right_entry;

            assign occ[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign left_lt    = 1'b1;
                assign left_entry = request.value;
            end
            else
            begin : g_inner
                assign left_lt    = lt[i-1];
                assign left_entry = entries[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_entry = entries[i];
            end
            else
            begin : g_body
                assign right_entry = entries[i+1];
            end

            ssid_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occ         (occ[i]),
                .left_lt     (left_lt),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entries[i]),
                .lt          (lt[i]),
                .eq          (eq[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.del)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        result_next.status = status;
        result_next.count  = COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/ssid_checker.sv =====
// Port-level checker for the sorted set insert/delete block, bound to the top level.
module ssid_checker
    import ssid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  request_t  request,
    input  logic      done,
    input  result_t   result
);

    // Every transfer yields exactly one result in the following cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("no result after a request transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without a request");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_FULL |-> result.count == COUNT_W'(CAPACITY))
        else $error("table full reported below capacity");

    a_dup_is_insert: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_DUP || result.status == ST_FULL)
        |-> $past(request.opcode) == OP_INSERT)
        else $error("insert status on a delete");

    a_missing_is_delete: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_MISSING |-> $past(request.opcode) == OP_DELETE)
        else $error("not-found status on an insert");

endmodule

bind sorted_set_insert_delete ssid_checker u_ssid_checker (.*);

// ===== tb/tb_sorted_set_insert_delete.sv =====
// Testbench for the sorted set insert/delete block, checking it against a table model.
module tb_sorted_set_insert_delete;
    timeunit 1ns;
    timeprecision 1ps;

    import ssid_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 30;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    request_t  request;
    logic      done;
    result_t   result;

    // Model of the table: ascending distinct values, as the block should hold them.
    logic signed [VALUE_W-1:0] held_values[$];
    result_t                   pending_results[$];

    logic signed [VALUE_W-1:0] corner_values[6] = '{
        VALUE_MIN, VALUE_MIN + 1, -1, 0, VALUE_MAX - 1, VALUE_MAX
    };

    int unsigned sender_idle_pct;
    int          cycle_count;
    int          mismatch_count;
    int          inserts_sent;
    int          deletes_sent;
    int          peak_fill;
    int          status_seen[4];

    sorted_set_insert_delete dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Applies one request to the model table and returns the result it should produce.
    function automatic result_t apply_to_table(input request_t req);
        logic signed [VALUE_W-1:0] key;
        int                        pos;
        result_t                   res;
        key = req.value;
        pos = 0;
        while (pos < held_values.size() && held_values[pos] < key)
            pos++;
        if (req.opcode == OP_INSERT)
        begin
            // A full table rejects the insert even when the value is already held.
            if (held_values.size() >= CAPACITY)
                res.status = ST_FULL;
            else if (pos < held_values.size() && held_values[pos] == key)
                res.status = ST_DUP;
            else
            begin
                held_values.insert(pos, key);
                res.status = ST_OK;
            end
        end
        else
        begin
            if (pos >= held_values.size() || held_values[pos] != key)
                res.status = ST_MISSING;
            else
            begin
                held_values.delete(pos);
                res.status = ST_OK;
            end
        end
        res.count = COUNT_W'(held_values.size());
        return res;
    endfunction

    // Sends one request and records its expected result once the transfer happens.
    task automatic send_request(input opcode_t op, input logic signed [VALUE_W-1:0] v);
        request_t req;
        req.opcode = op;
        req.value  = v;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_to_table(req));
        if (held_values.size() > peak_fill)
            peak_fill = held_values.size();
        if (op == OP_INSERT)
            inserts_sent++;
        else
            deletes_sent++;
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result status %0d count %0d with no request pending",
                                          result.status, result.count));
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result.status, want.status));
                if (result.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              result.count, want.count));
                status_seen[want.status]++;
            end
        end
    end

    task automatic test_empty_and_extremes();
        sender_idle_pct = 24;
        send_request(OP_DELETE, 5);          // delete from an empty table
        send_request(OP_INSERT, 0);
        send_request(OP_INSERT, 0);          // duplicate
        send_request(OP_INSERT, VALUE_MIN);
        send_request(OP_INSERT, VALUE_MAX);
        send_request(OP_DELETE, -1);         // value not held
        send_request(OP_DELETE, VALUE_MAX);
        send_request(OP_INSERT, VALUE_MAX);
        send_request(OP_INSERT, -1);
        send_request(OP_INSERT, 1);
    endtask

    task automatic test_full_table();
        // Descending keys land at many positions, both sides of zero.
        for (int k = 1; k <= 10; k++)
            send_request(OP_INSERT, 900 - 137 * k);
        send_request(OP_INSERT, 12345);      // table now full
        send_request(OP_INSERT, 54321);      // full
        send_request(OP_INSERT, 0);          // full wins over duplicate
        send_request(OP_DELETE, VALUE_MIN);
        send_request(OP_INSERT, 54321);
        send_request(OP_DELETE, VALUE_MAX);
    endtask

    // Alternates insert-heavy and delete-heavy stretches so the table swings between
    // empty and full; most keys come from a small pool so hits and duplicates are common.
    task automatic test_random_traffic(input int n_items, input int unsigned idle_pct);
        opcode_t                   op;
        logic signed [VALUE_W-1:0] v;
        int unsigned               insert_pct;
        int unsigned               pick;
        sender_idle_pct = idle_pct;
        insert_pct = 75;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 64 == 0)
                insert_pct = ((i / 64) % 2 == 0) ? 75 : 25;
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
            pick = $urandom_range(99);
            if (pick < 15)
                v = $urandom;
            else if (pick < 25)
                v = corner_values[$urandom_range(5)];
            else if (op == OP_DELETE && held_values.size() != 0 && pick < 70)
                v = held_values[$urandom_range(held_values.size() - 1)];
            else
                v = (int'($urandom_range(23)) - 12) * 32'sh0800_0001;
            send_request(op, v);
        end
    endtask

    initial
    begin
        start   <= 1'b0;
        request <= '0;
        rst_n   <= 1'b0;
        sender_idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extremes();
        test_full_table();
        wait_for_results();
        test_random_traffic(600, 24);
        wait_for_results();
        test_random_traffic(600, 62);
        wait_for_results();
        test_random_traffic(600, 0);
        wait_for_results();
        repeat (4) @(posedge clk);

        $display("Ran %0d inserts and %0d deletes at three sender idle rates; peak fill %0d of %0d.",
                 inserts_sent, deletes_sent, peak_fill, CAPACITY);
        $display("Results seen: ok %0d, duplicate %0d, full %0d, not found %0d; %0d mismatches.",
                 status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_FULL],
                 status_seen[ST_MISSING], mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ssid_pkg.sv
hdl/ssid_cell.sv
hdl/sorted_set_insert_delete.sv
hdl/ssid_checker.sv
tb/tb_sorted_set_insert_delete.sv
